// ----- rtl/crr_pkg.sv -----
// shared types and constants of the combination rank/unrank block
package crr_pkg;

  localparam int BW    = 63;  // binomial and rank width
  localparam int NROWS = 65;  // pascal rows 0..64
  localparam int PAW   = 7;   // pascal row address width

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_RANK   = 2'd1,
    FN_UNRANK = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEN   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic REG_DECK = 1'b0;
  localparam logic REG_HAND = 1'b1;

  typedef struct packed {
    logic init_step;
    logic load_wr;
    logic unrank_start;
    logic ins;
    logic rank_clear;
    logic sum_start;
    logic sum_sel;
    logic sum_acc;
    logic chk_err;
    logic out_err1;
    logic ucmp;
    logic emit_ld;
    logic out_pop;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic last_card;
    logic hand_ok;
    logic sum_done;
    logic rank_bad;
    logic ucmp_dec;
    logic i_one;
    logic out_last;
  } sts_t;

endpackage

// ----- rtl/crr_if.sv -----
// channel interfaces: input items, result items, configuration writes
interface crr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  card;
  logic [5:0]  position;
  logic        last_card;
  logic [62:0] rank_in;
  modport source (output valid, func, card, position, last_card, rank_in, input ready);
  modport sink (input valid, func, card, position, last_card, rank_in, output ready);
endinterface

interface crr_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] rank_out;
  logic [5:0]  card_out;
  logic        last;
  logic [1:0]  status;
  modport source (output valid, rank_out, card_out, last, status, input ready);
  modport sink (input valid, rank_out, card_out, last, status, output ready);
endinterface

interface crr_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/crr_ram.sv -----
// generic single write port ram with registered read
module crr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/crr_ctrl.sv -----
// controller state machine for rank, unrank and table init
module crr_ctrl import crr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  logic       out_ready,
  input  sts_t       sts,
  output logic       in_ready,
  output logic       out_valid,
  output cmd_t       cmd
);
  typedef enum logic [11:0] {
    S_INIT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RINS  = 12'b000000000100,
    S_SRD   = 12'b000000001000,
    S_SACC  = 12'b000000010000,
    S_UCRD  = 12'b000000100000,
    S_UCHK  = 12'b000001000000,
    S_URD   = 12'b000010000000,
    S_UCMP  = 12'b000100000000,
    S_ERD   = 12'b001000000000,
    S_ELD   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_LOAD: cmd.load_wr = 1'b1;
            FN_RANK: state_next = S_RINS;
            FN_UNRANK: begin
              cmd.unrank_start = 1'b1;
              state_next = S_UCRD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RINS: begin
        cmd.ins = 1'b1;
        if (!sts.last_card) begin
          state_next = S_IDLE;
        end else if (!sts.hand_ok) begin
          cmd.out_err1 = 1'b1;
          cmd.rank_clear = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.sum_start = 1'b1;
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        cmd.sum_sel = 1'b1;
        state_next = S_SACC;
      end
      S_SACC: begin
        cmd.sum_acc = 1'b1;
        if (sts.sum_done) begin
          cmd.rank_clear = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_SRD;
        end
      end
      S_UCRD: state_next = S_UCHK;
      S_UCHK: begin
        if (sts.rank_bad) begin
          cmd.chk_err = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_URD;
        end
      end
      S_URD: state_next = S_UCMP;
      S_UCMP: begin
        cmd.ucmp = 1'b1;
        if (!sts.ucmp_dec && sts.i_one) state_next = S_ERD;
        else state_next = S_URD;
      end
      S_ERD: state_next = S_ELD;
      S_ELD: begin
        cmd.emit_ld = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.out_pop = 1'b1;
            state_next = S_ERD;
          end
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ----- rtl/crr_dpath.sv -----
// datapath: deck tables, pascal table, sorted positions, descent and outputs
module crr_dpath import crr_pkg::*; #(
  parameter int MAX_DECK = 64,
  parameter int MAX_HAND = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic          in_accept,
  input  logic [5:0]    in_card,
  input  logic [5:0]    in_position,
  input  logic          in_last_card,
  input  logic [BW-1:0] in_rank,
  output logic [BW-1:0] rank_out,
  output logic [5:0]    card_out,
  output logic          last,
  output logic [1:0]    status
);
  localparam int NL = MAX_HAND + 1;

  logic [6:0]    deck_length;
  logic [4:0]    hand_size;
  logic [PAW-1:0] irow;
  logic [BW-1:0] rowv [NL];
  logic [BW*NL-1:0] row_flat, prow;
  logic [PAW-1:0] praddr;

  logic [4:0]    cnt, cnt_inc, k;
  logic [5:0]    sorted [MAX_HAND];
  logic [5:0]    sorted_nx [MAX_HAND];
  logic [5:0]    buf_pos [MAX_HAND];
  logic          last_r;
  logic [4:0]    i;
  logic [6:0]    v, deck_eff;
  logic [BW-1:0] rnk, acc;
  logic [BW-1:0] lane_i, lane_i1;
  logic [5:0]    sorted_i, buf_i;
  logic [5:0]    pos_rdata, cap_rdata;
  logic [MAX_HAND-1:0] gt;

  crr_ram #(.WIDTH(BW*NL), .DEPTH(NROWS)) u_pascal (
    .clk(clk), .we(cmd.init_step), .waddr(irow), .wdata(row_flat),
    .raddr(praddr), .rdata(prow)
  );

  crr_ram #(.WIDTH(6), .DEPTH(64)) u_pos (
    .clk(clk), .we(cmd.load_wr && in_accept), .waddr(in_card), .wdata(in_position),
    .raddr(in_card), .rdata(pos_rdata)
  );

  crr_ram #(.WIDTH(6), .DEPTH(64)) u_cap (
    .clk(clk), .we(cmd.load_wr && in_accept), .waddr(in_position), .wdata(in_card),
    .raddr(buf_i), .rdata(cap_rdata)
  );

  always_comb begin
    if (hand_size == 5'd0) k = 5'd1;
    else if (32'(hand_size) > MAX_HAND) k = 5'(MAX_HAND);
    else k = hand_size;
    if (32'(deck_length) > MAX_DECK) deck_eff = 7'(MAX_DECK);
    else deck_eff = deck_length;
    cnt_inc = (cnt == 5'd31) ? cnt : cnt + 5'd1;
  end

  always_comb begin
    sorted_i = '0;
    buf_i    = '0;
    for (int j = 0; j < MAX_HAND; j++) begin
      if (32'(i) == j) begin
        sorted_i = sorted[j];
        buf_i    = buf_pos[j];
      end
    end
    lane_i  = '0;
    lane_i1 = '0;
    for (int j = 0; j < NL; j++) begin
      if (32'(i) == j) lane_i = prow[j*BW +: BW];
      if (32'(i) + 1 == j) lane_i1 = prow[j*BW +: BW];
      row_flat[j*BW +: BW] = rowv[j];
    end
    praddr = cmd.sum_sel ? PAW'(sorted_i) : v;
  end

  // sorted insertion: entries above the new position move up one slot
  always_comb begin
    for (int j = 0; j < MAX_HAND; j++) begin
      gt[j] = (j < 32'(cnt)) && (sorted[j] > pos_rdata);
    end
    for (int j = 0; j < MAX_HAND; j++) begin
      sorted_nx[j] = sorted[j];
      if (j == 32'(cnt) || gt[j]) begin
        if (j > 0 && gt[(j > 0) ? j - 1 : 0]) sorted_nx[j] = sorted[(j > 0) ? j - 1 : 0];
        else sorted_nx[j] = pos_rdata;
      end
    end
  end

  always_comb begin
    sts.init_done = (irow == PAW'(NROWS - 1));
    sts.last_card = last_r;
    sts.hand_ok   = (cnt_inc == k);
    sts.sum_done  = (i + 5'd1 == k);
    sts.rank_bad  = (rnk >= lane_i);
    sts.ucmp_dec  = (lane_i > rnk) && (v != 7'd0);
    sts.i_one     = (i == 5'd1);
    sts.out_last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deck_length <= 7'd52;
      hand_size   <= 5'd5;
      irow        <= '0;
      cnt         <= '0;
      for (int j = 0; j < MAX_HAND; j++) sorted[j] <= '0;
      for (int j = 0; j < NL; j++) rowv[j] <= (j == 0) ? BW'(1) : '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DECK: deck_length <= cfg_data;
          REG_HAND: hand_size <= cfg_data[4:0];
          default: deck_length <= deck_length;
        endcase
      end
      // pascal rows are built one per cycle
      if (cmd.init_step) begin
        irow <= irow + PAW'(1);
        for (int j = 1; j < NL; j++) rowv[j] <= rowv[j] + rowv[j-1];
      end
      if (cmd.rank_clear) begin
        cnt <= '0;
        for (int j = 0; j < MAX_HAND; j++) sorted[j] <= '0;
      end else if (cmd.ins) begin
        if (cnt < k) sorted <= sorted_nx;
        cnt <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      last_r <= in_last_card;
    end
    if (cmd.unrank_start) begin
      rnk <= in_rank;
      v   <= deck_eff;
      i   <= k;
    end
    if (cmd.sum_start) begin
      i   <= '0;
      acc <= '0;
    end
    if (cmd.sum_acc) begin
      acc <= acc + lane_i1;
      i   <= i + 5'd1;
      rank_out <= acc + lane_i1;
      card_out <= '0;
      last     <= 1'b1;
      status   <= ST_OK;
    end
    if (cmd.out_err1) begin
      rank_out <= '0;
      card_out <= '0;
      last     <= 1'b1;
      status   <= ST_LEN;
    end
    if (cmd.chk_err) begin
      rank_out <= '0;
      card_out <= '0;
      last     <= 1'b1;
      status   <= ST_RANGE;
    end
    if (cmd.ucmp) begin
      if (sts.ucmp_dec) begin
        v <= v - 7'd1;
      end else begin
        for (int j = 0; j < MAX_HAND; j++) begin
          if (j + 1 == 32'(i)) buf_pos[j] <= v[5:0];
        end
        rnk <= rnk - lane_i;
        i   <= (i == 5'd1) ? 5'd0 : i - 5'd1;
      end
    end
    if (cmd.emit_ld) begin
      rank_out <= '0;
      card_out <= cap_rdata;
      last     <= (i + 5'd1 == k);
      status   <= ST_OK;
    end
    if (cmd.out_pop) begin
      i <= i + 5'd1;
    end
  end
endmodule

// ----- rtl/combination_rank_unrank.sv -----
// top level of the colex combination rank/unrank block
// After reset the block builds its binomial table (one pascal row per cycle into a
// row-wide ram) and takes no items then; configuration writes are taken at any time.
// A rank card passes an insert state; the card marked last adds a read and an
// accumulate state per hand card to sum the binomials, one table row read per term.
// An unrank passes a read and a range check state, then a read and a compare state
// per step of the greedy descent (one table read per step, at most clamped deck
// length plus used hand size steps), then a read, a load and an output state per card
// from the card lookup ram. Each result waits in an output register until taken.
module combination_rank_unrank import crr_pkg::*; #(
  parameter int MAX_DECK = 64,
  parameter int MAX_HAND = 16
) (
  input  logic      clk,
  input  logic      rst,
  crr_in_if.sink    din,
  crr_out_if.source dout,
  crr_cfg_if.sink   cfg
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign din.ready = in_ready;
  assign cfg.ready = 1'b1;

  crr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(din.valid), .in_func(din.func), .out_ready(dout.ready),
    .sts(sts), .in_ready(in_ready), .out_valid(dout.valid), .cmd(cmd)
  );

  crr_dpath #(.MAX_DECK(MAX_DECK), .MAX_HAND(MAX_HAND)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .in_accept(din.valid && in_ready),
    .in_card(din.card), .in_position(din.position),
    .in_last_card(din.last_card), .in_rank(din.rank_in),
    .rank_out(dout.rank_out), .card_out(dout.card_out),
    .last(dout.last), .status(dout.status)
  );
endmodule

// ----- test/crr_check.sv -----
// checker for the combination rank/unrank block: predicts results and compares them
`timescale 1ns / 100ps
module crr_check import crr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  crr_in_if.sink    din,
  crr_out_if.sink   dout,
  crr_cfg_if.sink   cfg,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic [62:0] rank_out;
    logic [5:0]  card_out;
    logic        last;
    logic [1:0]  status;
  } hand_res_t;

  logic [62:0] binom [0:64][0:64];
  logic [6:0]  deck_len;
  logic [4:0]  hand_sz;
  logic [5:0]  card_at [64];
  logic [5:0]  pos_of [64];
  logic [5:0]  held_pos [16];
  int          held_cnt;
  hand_res_t   hand_q [$];

  function automatic logic [62:0] choose(int n, int k);
    if (n > 64 || k > n || k < 0) return '0;
    return binom[n][k];
  endfunction

  function automatic int used_hand();
    if (hand_sz == 0) return 1;
    if (hand_sz > 16) return 16;
    return int'(hand_sz);
  endfunction

  task automatic predict(input logic [1:0] fn, input logic [5:0] cd, input logic [5:0] ps,
                         input logic lc, input logic [62:0] rk);
    int k, j, v, i;
    logic [5:0] p;
    logic [62:0] sum, b, r;
    int sel [16];
    k = used_hand();
    case (fn)
      FN_LOAD: begin
        card_at[ps] = cd;
        pos_of[cd] = ps;
      end
      FN_RANK: begin
        p = pos_of[cd];
        if (held_cnt < k) begin
          j = held_cnt;
          while (j > 0 && held_pos[j-1] > p) begin
            held_pos[j] = held_pos[j-1];
            j--;
          end
          held_pos[j] = p;
        end
        if (held_cnt < 31) held_cnt++;
        if (lc) begin
          if (held_cnt != k) hand_q.push_back('{'0, '0, 1'b1, ST_LEN});
          else begin
            sum = '0;
            for (i = 0; i < k; i++) sum += choose(held_pos[i], i + 1);
            hand_q.push_back('{sum, '0, 1'b1, ST_OK});
          end
          held_cnt = 0;
          foreach (held_pos[n]) held_pos[n] = '0;
        end
      end
      FN_UNRANK: begin
        v = deck_len > 64 ? 64 : int'(deck_len);
        r = rk;
        if (r >= choose(v, k)) hand_q.push_back('{'0, '0, 1'b1, ST_RANGE});
        else begin
          for (i = k; i >= 1; i--) begin
            b = choose(v, i);
            while (b > r && v > 0) begin
              v--;
              b = choose(v, i);
            end
            sel[i-1] = v;
            r -= b;
          end
          for (i = 0; i < k; i++)
            hand_q.push_back('{'0, card_at[sel[i][5:0]], i + 1 == k, ST_OK});
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    for (int n = 0; n <= 64; n++)
      for (int k = 0; k <= 64; k++)
        binom[n][k] = k == 0 ? 63'd1 : (k > n ? 63'd0 :
                      (k == n ? 63'd1 : binom[n-1][k-1] + binom[n-1][k]));
  end

  always @(posedge clk) begin
    hand_res_t exp_r, got;
    if (rst) begin
      deck_len <= 7'd52;
      hand_sz <= 5'd5;
      held_cnt = 0;
      foreach (held_pos[n]) held_pos[n] = '0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_DECK) deck_len <= cfg.data;
        else hand_sz <= cfg.data[4:0];
      end
      if (dout.valid && dout.ready) begin
        got = '{dout.rank_out, dout.card_out, dout.last, dout.status};
        if (hand_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = hand_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected rank %0d card %0d last %b status %0d",
                     $time, exp_r.rank_out, exp_r.card_out, exp_r.last, exp_r.status);
            $display("%0t:          actual   rank %0d card %0d last %b status %0d",
                     $time, got.rank_out, got.card_out, got.last, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (din.valid && din.ready)
        predict(din.func, din.card, din.position, din.last_card, din.rank_in);
      pending <= hand_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// testbench top: stimulus for the combination rank/unrank block and the verdict
`timescale 1ns / 100ps
module tb;
  import crr_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending;
  int   idle_pct = 29;
  int   quiet_cycles;
  int   cur_hand = 5;
  logic [5:0] deck_perm [64];

  crr_in_if  din();
  crr_out_if dout();
  crr_cfg_if cfg();

  combination_rank_unrank u_dut (.clk(clk), .rst(rst), .din(din), .dout(dout), .cfg(cfg));
  crr_check u_check (.clk(clk), .rst(rst), .din(din), .dout(dout), .cfg(cfg),
                     .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) dout.ready <= ($urandom_range(99) >= idle_pct);

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // valid stays up after a transaction so the next one can follow at once
  task automatic send(input logic [1:0] fn, input logic [5:0] cd, input logic [5:0] ps,
                      input logic lc, input logic [62:0] rk);
    while ($urandom_range(99) < idle_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid <= 1'b1; din.func <= fn; din.card <= cd; din.position <= ps;
    din.last_card <= lc; din.rank_in <= rk;
    do @(posedge clk); while (!din.ready);
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_HAND) cur_hand = val;
  endtask

  // load a shuffled deck covering all 64 positions and cards
  task automatic load_deck();
    int j;
    logic [5:0] t;
    foreach (deck_perm[i]) deck_perm[i] = i[5:0];
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(i);
      t = deck_perm[i]; deck_perm[i] = deck_perm[j]; deck_perm[j] = t;
    end
    for (int i = 0; i < 64; i++) send(FN_LOAD, deck_perm[i], i[5:0], 1'b0, '0);
  endtask

  task automatic rank_hand(input int n);
    for (int i = 0; i < n; i++)
      send(FN_RANK, 6'($urandom_range(63)), 6'($urandom), i == n - 1, '0);
  endtask

  function automatic logic [62:0] rand_rank();
    logic [62:0] r;
    r = 63'({$urandom, $urandom});
    case ($urandom_range(3))
      0: return r;
      1: return r & 63'hff;
      2: return r & 63'hfffff;
      default: return r & 63'hffffffffff;
    endcase
  endfunction

  initial begin
    int n, hs;
    din.valid = 1'b0; din.func = FN_NONE; din.card = '0; din.position = '0;
    din.last_card = 1'b0; din.rank_in = '0;
    cfg.valid = 1'b0; cfg.index = REG_DECK; cfg.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    load_deck();
    // directed: reset settings, rank length cases, unrank extremes, ignored code
    rank_hand(5);
    rank_hand(4);
    rank_hand(7);
    send(FN_RANK, 6'd63, 6'd0, 1'b1, '0);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, 63'd0);
    send(FN_UNRANK, 6'd63, 6'd63, 1'b0, 63'd2598959);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, 63'd2598960);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, '1);
    send(FN_NONE, 6'd63, 6'd63, 1'b1, '1);
    drain();
    write_reg(REG_DECK, 7'd64); write_reg(REG_HAND, 7'd16);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, 63'd488526937079580 - 63'd1);
    rank_hand(16);
    drain();
    write_reg(REG_DECK, 7'd1); write_reg(REG_HAND, 7'd1);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, 63'd0);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, 63'd1);
    rank_hand(1);
    drain();
    write_reg(REG_DECK, 7'd127); write_reg(REG_HAND, 7'd0);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, 63'd63);
    drain();
    write_reg(REG_DECK, 7'd0); write_reg(REG_HAND, 7'd31);
    send(FN_UNRANK, 6'd0, 6'd0, 1'b0, 63'd0);
    drain();
    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph == 4) ? 0 : 29;
      n = $urandom_range(64, 2);
      hs = $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(n < 8 ? n : 8, 1);
      write_reg(REG_DECK, n[6:0]); write_reg(REG_HAND, hs[6:0]);
      if (ph == 6) load_deck();
      for (int it = 0; it < 5; it++) begin
        case ($urandom_range(9))
          0: send(FN_LOAD, deck_perm[$urandom_range(63)], 6'($urandom), 1'b0, '0);
          1: send(FN_NONE, 6'($urandom), 6'($urandom), 1'($urandom), rand_rank());
          2, 3, 4: rank_hand($urandom_range(3) == 0 ? $urandom_range(18, 1)
                             : (cur_hand == 0 ? 1 : (cur_hand > 16 ? 16 : cur_hand)));
          default: send(FN_UNRANK, 6'($urandom), 6'($urandom), 1'($urandom), rand_rank());
        endcase
        if (ph == 2 && it == 2) begin
          din.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end
    idle_pct = 29;
    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
